/* rtl/core/mmcp_pkg.sv */
// ============================================================================
// mmcp_pkg
// Shared types and constants of the multi-mode channel processor.
// ============================================================================
package mmcp_pkg;

    localparam int VALUE_WIDTH_DEFAULT   = 32;
    localparam int DIVIDER_WIDTH_DEFAULT = 8;
    localparam int FRAC_BITS             = 16;
    localparam int CFG_INDEX_WIDTH       = 3;
    localparam int MODE_WIDTH            = 3;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_PASS      = 3'd0,
        MODE_MIN       = 3'd1,
        MODE_MAX       = 3'd2,
        MODE_COUNT     = 3'd3,
        MODE_CLAMP     = 3'd4,
        MODE_INTEGRATE = 3'd5,
        MODE_HOLD      = 3'd6
    } mode_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MODE        = 3'd0,
        REG_UPPER_LIMIT = 3'd1,
        REG_LOWER_LIMIT = 3'd2,
        REG_DIVIDER     = 3'd3,
        REG_USE_LINK    = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_UPDATE
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted beat, seed the divider
        logic step;      // one quotient bit
        logic commit;    // write the new channel value
    } mmcp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic integrate;
    } mmcp_status_t;

endpackage

/* rtl/core/mmcp_if.sv */
// ============================================================================
// mmcp channel interfaces
// Valid/ready channels for samples, channel values and register writes.
// ============================================================================
interface mmcp_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sample;
    logic signed [VALUE_WIDTH-1:0] linked_sample;

    modport source (output valid, output sample, output linked_sample, input ready);
    modport sink   (input valid, input sample, input linked_sample, output ready);
endinterface

interface mmcp_out_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] channel_value;

    modport source (output valid, output channel_value, input ready);
    modport sink   (input valid, input channel_value, output ready);
endinterface

interface mmcp_cfg_if #(
    parameter int INDEX_WIDTH = 3,
    parameter int DATA_WIDTH  = 32
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] index;
    logic [DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/mmcp_ctrl.sv */
// ============================================================================
// mmcp_ctrl
// Sequencer: input handshake, divide bit counter, output valid.
// ============================================================================
module mmcp_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mmcp_pkg::mmcp_status_t status,
    output mmcp_pkg::mmcp_cmd_t    cmd
);
    import mmcp_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = CNT_W'(VALUE_WIDTH - 1);
                    state_next  = status.integrate ? ST_DIVIDE : ST_UPDATE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/mmcp_datapath.sv */
// ============================================================================
// mmcp_datapath
// Config registers, sample latch, restoring divider and channel value update.
// ============================================================================
module mmcp_datapath #(
    parameter int VALUE_WIDTH   = 32,
    parameter int DIVIDER_WIDTH = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mmcp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [VALUE_WIDTH-1:0]                  cfg_data,
    input  logic signed [VALUE_WIDTH-1:0]           sample,
    input  logic signed [VALUE_WIDTH-1:0]           linked_sample,
    output logic signed [VALUE_WIDTH-1:0]           channel_value,
    input  mmcp_pkg::mmcp_cmd_t                     cmd,
    output mmcp_pkg::mmcp_status_t                  status
);
    import mmcp_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int DW = DIVIDER_WIDTH;
    localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
    // 1.0 in Q.FRAC_BITS, or the largest value when 1.0 does not fit
    localparam logic signed [W-1:0] COUNT_UNIT =
        (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : VAL_MAX;

    // configuration
    mode_t                 mode_reg;
    logic signed [W-1:0]   upper_reg;
    logic signed [W-1:0]   lower_reg;
    logic [DW-1:0]         divider_reg;
    logic                  use_link_reg;

    // state
    logic signed [W-1:0]   held_reg, held_next;
    logic signed [W-1:0]   prev_reg;

    // latched beat and divider
    logic signed [W-1:0]   sample_reg;
    logic signed [W-1:0]   linked_reg;
    logic                  neg_reg;
    logic [W-1:0]          quot_reg;
    logic [DW-1:0]         rem_reg;

    logic [DW:0]           trial;
    logic                  trial_ge;
    logic [W-1:0]          abs_sample;
    logic signed [W-1:0]   quotient;
    logic signed [W-1:0]   src;
    logic signed [W-1:0]   add_b;
    logic signed [W:0]     sum;
    logic signed [W-1:0]   sat_sum;
    logic                  do_add;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_PASS;
            upper_reg    <= '0;
            lower_reg    <= '0;
            divider_reg  <= DW'(1);
            use_link_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:        mode_reg     <= mode_t'(cfg_data[MODE_WIDTH-1:0]);
                REG_UPPER_LIMIT: upper_reg    <= cfg_data;
                REG_LOWER_LIMIT: lower_reg    <= cfg_data;
                REG_DIVIDER:     divider_reg  <= cfg_data[DW-1:0];
                REG_USE_LINK:    use_link_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign status.integrate = (mode_reg == MODE_INTEGRATE);

    // |sample| fits in W unsigned bits, including the most negative value
    assign abs_sample = sample[W-1] ? W'(-sample) : W'(sample);
    assign trial      = {rem_reg, quot_reg[W-1]};
    assign trial_ge   = (trial >= {1'b0, divider_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            linked_reg <= linked_sample;
            neg_reg    <= sample[W-1];
            quot_reg   <= abs_sample;
            rem_reg    <= '0;
        end
        else if (cmd.step)
        begin
            quot_reg <= {quot_reg[W-2:0], trial_ge};
            rem_reg  <= trial_ge ? DW'(trial - {1'b0, divider_reg}) : trial[DW-1:0];
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign quotient = neg_reg ? -$signed(quot_reg) : $signed(quot_reg);
    assign src      = use_link_reg ? linked_reg : sample_reg;

    always_comb
    begin
        add_b  = quotient;
        do_add = 1'b0;
        if (mode_reg == MODE_COUNT)
        begin
            add_b  = COUNT_UNIT;
            do_add = (sample_reg > upper_reg) && (prev_reg < upper_reg);
        end
        else if (mode_reg == MODE_INTEGRATE)
        begin
            do_add = (divider_reg != '0);
        end
    end

    assign sum     = {held_reg[W-1], held_reg} + {add_b[W-1], add_b};
    assign sat_sum = (sum[W] != sum[W-1]) ? (sum[W] ? VAL_MIN : VAL_MAX) : sum[W-1:0];

    always_comb
    begin
        held_next = held_reg;
        unique case (mode_reg) inside
            MODE_PASS:
                held_next = src;
            MODE_MIN:
                if (src < held_reg)
                    held_next = src;
            MODE_MAX:
                if (src > held_reg)
                    held_next = src;
            MODE_COUNT, MODE_INTEGRATE:
                if (do_add)
                    held_next = sat_sum;
            MODE_CLAMP:
            begin
                held_next = sample_reg;
                if (sample_reg > upper_reg)
                    held_next = upper_reg;
                if (sample_reg < lower_reg)
                    held_next = lower_reg;
            end
            default:
                held_next = held_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            prev_reg <= '0;
        end
        else if (cmd.commit)
        begin
            held_reg <= held_next;
            if (mode_reg == MODE_COUNT)
                prev_reg <= sample_reg;
        end
    end

    // held value only moves on commit, which waits for the output to drain
    assign channel_value = held_reg;

endmodule

/* rtl/core/multi_mode_channel_processor_top.sv */
// ============================================================================
// multi_mode_channel_processor_top
// Channel value processor: pass, min, max, count, clamp, integrate, hold.
// ============================================================================
//  channel   dir  payload                       handshake
//  in_ch     in   sample, linked_sample         valid / ready
//  out_ch    out  channel_value                 valid / ready
//  cfg       in   index, data                   valid / ready (ready tied high)
//
//  Integrate mode: the restoring divider runs in the divide state between accept
//  and update, one quotient bit per cycle. Other modes go from accept to update.
//  One beat in flight; a new beat is taken while the last result waits.
//  Reset clears config, held value and previous sample; no clearing pass.
//  A stalled output holds the sequencer in its update state.
// ============================================================================
module multi_mode_channel_processor_top #(
    parameter int VALUE_WIDTH   = mmcp_pkg::VALUE_WIDTH_DEFAULT,
    parameter int DIVIDER_WIDTH = mmcp_pkg::DIVIDER_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    mmcp_in_if.sink     in_ch,
    mmcp_out_if.source  out_ch,
    mmcp_cfg_if.sink    cfg
);
    import mmcp_pkg::*;

    mmcp_cmd_t    cmd;
    mmcp_status_t status;

    mmcp_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mmcp_datapath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg.valid),
        .cfg_ready     (cfg.ready),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .sample        (in_ch.sample),
        .linked_sample (in_ch.linked_sample),
        .channel_value (out_ch.channel_value),
        .cmd           (cmd),
        .status        (status)
    );

    // no second beat right behind an accepted one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input taken while a beat is in flight");

    // a committed value is presented on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_ch.valid)
        else $error("commit did not raise output valid");

    // commit never overlaps an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !in_ch.ready && !cmd.capture)
        else $error("commit overlapped input accept");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for multi_mode_channel_processor_top. A behavioral
// predictor tracks the channel value and the configuration; every output
// beat is compared in order with the value predicted when its sample beat
// was accepted. Directed cases come first, then random traffic under three
// idle profiles and one long output stall.
// ============================================================================
module testbench;
    import mmcp_pkg::*;

    localparam int     VW             = VALUE_WIDTH_DEFAULT;
    localparam int     DW             = DIVIDER_WIDTH_DEFAULT;
    localparam longint VAL_MAX        = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_MIN        = -VAL_MAX - 1;
    localparam longint ONE_UNIT       = longint'(1) <<< FRAC_BITS;
    localparam int     LIMIT_CYCLES   = 400000;
    localparam int     STALL_CYCLES   = 300;
    localparam int     RANDOM_ITEMS   = 300;

    // codes outside the package enums
    localparam logic [MODE_WIDTH-1:0]      MODE_SPARE    = 3'd7;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO  = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_MID = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI  = 3'd7;

    localparam logic signed [VW-1:0] POS_MAX = VAL_MAX[VW-1:0];
    localparam logic signed [VW-1:0] NEG_MAX = VAL_MIN[VW-1:0];

    logic clk;
    logic rst_n;

    mmcp_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
    mmcp_out_if #(.VALUE_WIDTH(VW)) out_ch ();
    mmcp_cfg_if #(.INDEX_WIDTH(CFG_INDEX_WIDTH), .DATA_WIDTH(VW)) cfg_ch ();

    multi_mode_channel_processor_top #(
        .VALUE_WIDTH   (VW),
        .DIVIDER_WIDTH (DW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // predictor state and configuration shadow
    logic [MODE_WIDTH-1:0]  cfg_mode;
    logic signed [VW-1:0]   cfg_upper;
    logic signed [VW-1:0]   cfg_lower;
    logic [DW-1:0]          cfg_divider;
    logic                   cfg_use_link;
    logic signed [VW-1:0]   chan_value;
    logic signed [VW-1:0]   last_count_sample;

    logic signed [VW-1:0]   expected_values[$];
    int                     n_errors;
    int                     n_checked;
    int                     tx_idle_pct;
    int                     rx_idle_pct;
    int                     cycle_count;
    logic                   rx_hold;
    event                   hold_go;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic signed [VW-1:0] sat_sum(logic signed [VW-1:0] a, longint b);
        longint s;
        s = longint'(a) + b;
        if (s > VAL_MAX)
            s = VAL_MAX;
        if (s < VAL_MIN)
            s = VAL_MIN;
        return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] update_channel(logic signed [VW-1:0] s,
                                                            logic signed [VW-1:0] l);
        logic signed [VW-1:0] src;
        logic signed [VW-1:0] v;
        src = cfg_use_link ? l : s;
        case (cfg_mode)
            MODE_PASS: chan_value = src;
            MODE_MIN:
            begin
                if (src < chan_value)
                    chan_value = src;
            end
            MODE_MAX:
            begin
                if (src > chan_value)
                    chan_value = src;
            end
            MODE_COUNT:
            begin
                // strict rise across the threshold against the previous sample
                if (s > cfg_upper && last_count_sample < cfg_upper)
                    chan_value = sat_sum(chan_value, ONE_UNIT);
                last_count_sample = s;
            end
            MODE_CLAMP:
            begin
                v = s;
                if (s > cfg_upper)
                    v = cfg_upper;
                if (s < cfg_lower)
                    v = cfg_lower;
                chan_value = v;
            end
            MODE_INTEGRATE:
            begin
                if (cfg_divider != 0)
                    chan_value = sat_sum(chan_value, longint'(s) / longint'(cfg_divider));
            end
            default: ;
        endcase
        return chan_value;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random ready, long stall on request, in-order check
    // ------------------------------------------------------------------------
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (STALL_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    initial
    begin
        logic signed [VW-1:0] want;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("channel_value: expected none, actual %0d", out_ch.channel_value);
                    n_errors++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    n_checked++;
                    if (out_ch.channel_value !== want)
                    begin
                        $error("channel_value: expected %0d, actual %0d",
                               want, out_ch.channel_value);
                        n_errors++;
                    end
                end
            end
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_beat(logic signed [VW-1:0] s, logic signed [VW-1:0] l);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.sample        <= s;
        in_ch.linked_sample <= l;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        expected_values.push_back(update_channel(s, l));
    endtask

    // valid stays high on return; end_config lowers it
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [VW-1:0] word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            REG_MODE:        cfg_mode     = word[MODE_WIDTH-1:0];
            REG_UPPER_LIMIT: cfg_upper    = word;
            REG_LOWER_LIMIT: cfg_lower    = word;
            REG_DIVIDER:     cfg_divider  = word[DW-1:0];
            REG_USE_LINK:    cfg_use_link = word[0];
            default: ;
        endcase
    endtask

    task automatic end_config();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_config(logic [VW-1:0] mode_word, logic signed [VW-1:0] upper,
                                logic signed [VW-1:0] lower, logic [VW-1:0] div_word,
                                logic [VW-1:0] link_word);
        wait_drain();
        write_reg(REG_MODE, mode_word);
        write_reg(REG_UPPER_LIMIT, upper);
        write_reg(REG_LOWER_LIMIT, lower);
        write_reg(REG_DIVIDER, div_word);
        write_reg(REG_USE_LINK, link_word);
        end_config();
    endtask

    // ------------------------------------------------------------------------
    // Value generators
    // ------------------------------------------------------------------------
    function automatic logic signed [VW-1:0] fit(longint v);
        if (v > VAL_MAX)
            v = VAL_MAX;
        if (v < VAL_MIN)
            v = VAL_MIN;
        return v[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] rand_value(logic signed [VW-1:0] center);
        longint v;
        case ($urandom_range(9))
            0: v = VAL_MAX;
            1: v = VAL_MIN;
            2, 3: return $urandom;
            4, 5, 6: v = longint'(center) + longint'($urandom_range(8)) - 4;
            default: v = longint'(center) + (longint'($signed($urandom)) >>> 12);
        endcase
        return fit(v);
    endfunction

    // just above or below the threshold, now and then right on it
    function automatic logic signed [VW-1:0] near_value(logic signed [VW-1:0] center,
                                                        logic above);
        longint d;
        if ($urandom_range(7) == 0)
            return center;
        d = longint'($urandom_range(2000, 1));
        return fit(above ? longint'(center) + d : longint'(center) - d);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_select_modes();
        apply_config(MODE_PASS, 0, 0, 1, 0);
        send_beat(POS_MAX, 0);
        send_beat(NEG_MAX, POS_MAX);
        apply_config(MODE_PASS, 0, 0, 1, 1);
        send_beat(0, POS_MAX);
        apply_config(MODE_MIN, 0, 0, 1, 0);
        send_beat(5, NEG_MAX);
        send_beat(NEG_MAX, 7);
        apply_config(MODE_MAX, 0, 0, 1, 1);
        send_beat(NEG_MAX, POS_MAX);
    endtask

    task automatic test_count();
        apply_config(MODE_COUNT, 0, 0, 1, 0);
        send_beat(1, 0);        // previous sample equals threshold: no count
        send_beat(-1, 0);
        send_beat(1, 0);        // rising crossing
        send_beat(0, 0);
        apply_config(MODE_PASS, 0, 0, 1, 0);
        send_beat(fit(VAL_MAX - 100), 0);
        apply_config(MODE_COUNT, 0, 0, 1, 0);
        send_beat(-5, 0);
        send_beat(5, 0);        // saturates at the top
    endtask

    task automatic test_clamp();
        apply_config(MODE_CLAMP, 100 <<< FRAC_BITS, -(100 <<< FRAC_BITS), 1, 0);
        send_beat(POS_MAX, 0);
        send_beat(NEG_MAX, 0);
        send_beat(3, 0);
        // crossed limits: lower one wins
        apply_config(MODE_CLAMP, -10, 10, 1, 0);
        send_beat(0, 0);
    endtask

    task automatic test_integrate();
        apply_config(MODE_INTEGRATE, 0, 0, 1, 0);
        send_beat(POS_MAX, 0);
        send_beat(POS_MAX, 0);
        apply_config(MODE_INTEGRATE, 0, 0, 255, 0);
        send_beat(NEG_MAX, 0);
        apply_config(MODE_INTEGRATE, 0, 0, 2, 0);
        send_beat(-3, 0);       // truncates toward zero
        apply_config(MODE_INTEGRATE, 0, 0, 0, 0);
        send_beat(12345, 0);    // zero divider holds
        apply_config(MODE_INTEGRATE, 0, 0, 1, 0);
        send_beat(NEG_MAX, 0);
        send_beat(NEG_MAX, 0);
    endtask

    task automatic test_hold_and_spare_codes();
        apply_config(MODE_HOLD, 0, 0, 1, 0);
        send_beat(1, 1);
        apply_config(MODE_SPARE, 0, 0, 1, 0);
        send_beat(2, 2);
        wait_drain();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_MID, '1);
        write_reg(REG_SPARE_HI, '1);
        end_config();
        send_beat(3, 3);
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
        int                    left;
        int                    seg;
        logic [MODE_WIDTH-1:0] m;
        logic signed [VW-1:0]  up;
        logic signed [VW-1:0]  lo;
        logic signed [VW-1:0]  tmp;
        logic signed [VW-1:0]  s;
        logic [DW-1:0]         dv;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        left = n_items;
        while (left > 0)
        begin
            m  = MODE_WIDTH'($urandom_range(7));
            up = rand_value(0);
            lo = rand_value(0);
            if (m == MODE_CLAMP && lo > up && $urandom_range(3) != 0)
            begin
                tmp = up;
                up  = lo;
                lo  = tmp;
            end
            case ($urandom_range(5))
                0: dv = '0;
                1: dv = DW'(1);
                2: dv = '1;
                default: dv = DW'($urandom_range(255, 1));
            endcase
            // junk in the unused data bits must be ignored
            apply_config(VW'({$urandom, m}), up, lo, VW'({$urandom, dv}),
                         VW'({$urandom, 1'($urandom)}));
            seg = $urandom_range(40, 8);
            if (seg > left)
                seg = left;
            for (int i = 0; i < seg; i++)
            begin
                if (m == MODE_COUNT && $urandom_range(4) != 0)
                    s = near_value(up, i[0]);
                else
                    s = rand_value(up);
                send_beat(s, rand_value(up));
            end
            left -= seg;
        end
    endtask

    task automatic test_output_stall();
        apply_config(MODE_PASS, 0, 0, 1, 0);
        tx_idle_pct = 0;
        -> hold_go;
        for (int i = 0; i < 24; i++)
            send_beat($urandom, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.sample        = '0;
        in_ch.linked_sample = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        n_errors            = 0;
        n_checked           = 0;
        tx_idle_pct         = 31;
        rx_idle_pct         = 83;
        cfg_mode            = MODE_PASS;
        cfg_upper           = '0;
        cfg_lower           = '0;
        cfg_divider         = DW'(1);
        cfg_use_link        = 1'b0;
        chan_value          = '0;
        last_count_sample   = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_select_modes();
        test_count();
        test_clamp();
        test_integrate();
        test_hold_and_spare_codes();
        test_random_traffic(31, 83, RANDOM_ITEMS);
        test_random_traffic(83, 31, RANDOM_ITEMS);
        test_random_traffic(0, 0, RANDOM_ITEMS);
        test_output_stall();

        wait_drain();
        repeat (VW + 8) @(posedge clk);

        $display("%0d channel values checked across all modes, spare mode and register codes,",
                 n_checked);
        $display("limit and divider extremes, linked source, idle profiles and a long stall");
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
